// ----- rtl/core/circular_list_position_engine_unit_defines.svh -----
// Assertion macros shared by the list engine RTL.
// Included by circular_list_position_engine_unit.sv; depends on nothing else.
`ifndef CIRCULAR_LIST_POSITION_ENGINE_UNIT_DEFINES_SVH
`define CIRCULAR_LIST_POSITION_ENGINE_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define CLPE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define CLPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/clpe_pkg.sv -----
// Types and constants of the circular list position engine.
// No dependencies; imported by circular_list_position_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

package clpe_pkg;

    // Field widths of the stream items.
    localparam int OPCODE_W    = 2;
    localparam int POS_W       = 6;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2,
        OP_SEARCH   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_WALK,
        S_INS_W1,
        S_INS_W2
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/circular_list_position_engine_unit.sv -----
// Circular list position engine: sequencer, slot pool memories and result register.
// Depends on clpe_pkg and circular_list_position_engine_unit_defines.svh.
//
// This block keeps an ordered circular singly linked list of DATA_WIDTH-bit values in a
// pool of CAPACITY slots and takes one command transaction at a time: insert at a 1-based
// position, delete at a position, traverse, or search for a value. Every command gives
// at least one result transaction, and the final one carries tlast. The list is walked
// through the link memory at one read per cycle while the result side does not stall. An
// insert finds the lowest free slot by a scan of one slot per cycle that runs beside the
// walk. A stalled result side holds the command until it can take the result.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_list_position_engine_unit_defines.svh"

module circular_list_position_engine_unit #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Command side.
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // Fields from bit 0 up: position[5:0], value[37:6], zero fill [39:38].
    input  wire logic [clpe_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Fields from bit 0 up: opcode[1:0].
    input  wire logic [clpe_pkg::OPCODE_W-1:0]    i_s_tuser,
    // Result side.
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // Fields from bit 0 up: status[2:0], value_out[34:3], position_out[40:35],
    // zero fill [47:41].
    output logic [clpe_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                  o_m_tlast
);

    import clpe_pkg::*;

    localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int FILL = OUT_TDATA_W - POS_W - VALUE_W - STATUS_W;

    // Slot pool memories.
    logic [DATA_WIDTH-1:0] mem_value [CAPACITY];
    logic [SW-1:0]         mem_link  [CAPACITY];

    // Control state.
    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [SW-1:0]         r_head, n_head;
    logic [SW-1:0]         r_tail, n_tail;
    logic [CAPACITY-1:0]   r_used, n_used;
    logic                  r_fs_busy, n_fs_busy;
    logic                  r_ovalid, n_ovalid;

    // Payload state.
    t_op                   r_op, n_op;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    t_status               r_st, n_st;
    logic [SW-1:0]         r_cur, n_cur;
    logic [SW-1:0]         r_prv, n_prv;
    logic [CW-1:0]         r_idx, n_idx;
    logic [SW-1:0]         r_fs, n_fs;
    t_status               r_ostatus, n_ostatus;
    logic [VALUE_W-1:0]    r_ovalue, n_ovalue;
    logic [POS_W-1:0]      r_opos, n_opos;
    logic                  r_olast, n_olast;

    // Registered memory read data.
    logic [DATA_WIDTH-1:0] r_rd_value;
    logic [SW-1:0]         r_rd_link;

    // Memory port controls.
    logic                  rd_en;
    logic [SW-1:0]         rd_addr;
    logic                  vwr_en;
    logic [SW-1:0]         vwr_addr;
    logic [DATA_WIDTH-1:0] vwr_data;
    logic                  lwr_en;
    logic [SW-1:0]         lwr_addr;
    logic [SW-1:0]         lwr_data;

    // Decoded input fields and helpers.
    t_op                   in_op;
    logic [POS_W-1:0]      in_pos;
    logic [63:0]           in_val64;
    logic [CMPW-1:0]       in_pos_w;
    logic [CMPW-1:0]       pos_w;
    logic [CMPW-1:0]       cnt_w;
    logic [CMPW-1:0]       idx_w;
    logic                  in_acc;
    logic                  out_free;

    // Sign-extend a stored value and cut it to the result width.
    function automatic logic [VALUE_W-1:0] f_report(input logic [DATA_WIDTH-1:0] x);
        logic [63:0] w;
        w = 64'(signed'(x));
        return w[VALUE_W-1:0];
    endfunction

    assign in_op    = t_op'(i_s_tuser);
    assign in_pos   = i_s_tdata[POS_W-1:0];
    assign in_val64 = 64'(signed'(i_s_tdata[POS_W+VALUE_W-1:POS_W]));
    assign in_pos_w = CMPW'(in_pos);
    assign pos_w    = CMPW'(r_pos);
    assign cnt_w    = CMPW'(r_cnt);
    assign idx_w    = CMPW'(r_idx);

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {FILL'(0), r_opos, r_ovalue, r_ostatus};

    // Sequencer: next state, list bookkeeping, memory ports and result loads.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_head    = r_head;
        n_tail    = r_tail;
        n_used    = r_used;
        n_fs_busy = r_fs_busy;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_st      = r_st;
        n_cur     = r_cur;
        n_prv     = r_prv;
        n_idx     = r_idx;
        n_fs      = r_fs;
        n_ostatus = r_ostatus;
        n_ovalue  = r_ovalue;
        n_opos    = r_opos;
        n_olast   = r_olast;
        rd_en     = 1'b0;
        rd_addr   = r_rd_link;
        vwr_en    = 1'b0;
        vwr_addr  = r_fs;
        vwr_data  = r_val;
        lwr_en    = 1'b0;
        lwr_addr  = r_fs;
        lwr_data  = r_fs;

        // The free-slot scan steps one slot per cycle until it meets an unused one.
        if (r_fs_busy) begin
            if (!r_used[r_fs]) begin
                n_fs_busy = 1'b0;
            end else begin
                n_fs = r_fs + SW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = in_op;
                    n_pos = in_pos;
                    n_val = in_val64[DATA_WIDTH-1:0];
                    n_cur = r_head;
                    n_prv = r_head;
                    n_idx = CW'(1);
                    if (in_op == OP_INSERT) begin
                        if (in_pos_w == '0 || in_pos_w > cnt_w + CMPW'(1)) begin
                            n_st    = ST_BAD_POS;
                            n_state = S_ERR;
                        end else if (cnt_w == CMPW'(CAPACITY)) begin
                            n_st    = ST_FULL;
                            n_state = S_ERR;
                        end else begin
                            n_fs      = '0;
                            n_fs_busy = 1'b1;
                            if (r_cnt != '0 && in_pos_w >= CMPW'(2)) begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_state = S_WALK;
                            end else begin
                                n_state = S_INS_W1;
                            end
                        end
                    end else if (r_cnt == '0) begin
                        n_st    = ST_EMPTY;
                        n_state = S_ERR;
                    end else if (in_op == OP_DELETE &&
                                 (in_pos_w == '0 || in_pos_w > cnt_w)) begin
                        n_st    = ST_BAD_POS;
                        n_state = S_ERR;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_head;
                        n_state = S_WALK;
                    end
                end
            end

            // A rejected command gives one error result.
            S_ERR: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_st;
                    n_ovalue  = '0;
                    n_opos    = '0;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // Read data holds slot r_cur at list position r_idx.
            S_WALK: begin
                case (r_op)
                    OP_INSERT: begin
                        if (idx_w + CMPW'(1) == pos_w) begin
                            n_state = S_INS_W1;
                        end else begin
                            rd_en = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (idx_w == pos_w) begin
                            if (out_free) begin
                                if (r_pos == POS_W'(1)) begin
                                    if (r_cnt == CW'(1)) begin
                                        n_head = '0;
                                        n_tail = '0;
                                    end else begin
                                        n_head   = r_rd_link;
                                        lwr_en   = 1'b1;
                                        lwr_addr = r_tail;
                                        lwr_data = r_rd_link;
                                    end
                                end else begin
                                    lwr_en   = 1'b1;
                                    lwr_addr = r_prv;
                                    lwr_data = r_rd_link;
                                    if (r_cur == r_tail) begin
                                        n_tail = r_prv;
                                    end
                                end
                                n_used[r_cur] = 1'b0;
                                n_cnt         = r_cnt - CW'(1);
                                n_ovalid      = 1'b1;
                                n_ostatus     = ST_OK;
                                n_ovalue      = f_report(r_rd_value);
                                n_opos        = r_pos;
                                n_olast       = 1'b1;
                                n_state       = S_IDLE;
                            end
                        end else begin
                            rd_en = 1'b1;
                        end
                    end
                    OP_TRAVERSE: begin
                        if (out_free) begin
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_OK;
                            n_ovalue  = f_report(r_rd_value);
                            n_opos    = POS_W'(r_idx);
                            n_olast   = (r_idx == r_cnt);
                            if (r_idx == r_cnt) begin
                                n_state = S_IDLE;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (r_rd_value == r_val) begin
                            if (out_free) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_OK;
                                n_ovalue  = f_report(r_rd_value);
                                n_opos    = POS_W'(r_idx);
                                n_olast   = 1'b1;
                                n_state   = S_IDLE;
                            end
                        end else if (r_idx == r_cnt) begin
                            if (out_free) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_NOT_FOUND;
                                n_ovalue  = '0;
                                n_opos    = '0;
                                n_olast   = 1'b1;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            rd_en = 1'b1;
                        end
                    end
                endcase
                // Follow the link just read to the next slot.
                if (rd_en) begin
                    rd_addr = r_rd_link;
                    n_prv   = r_cur;
                    n_cur   = r_rd_link;
                    n_idx   = r_idx + CW'(1);
                end
            end

            // Fill the new slot once the scan has found it.
            S_INS_W1: begin
                if (!r_fs_busy) begin
                    vwr_en   = 1'b1;
                    vwr_addr = r_fs;
                    vwr_data = r_val;
                    lwr_en   = 1'b1;
                    lwr_addr = r_fs;
                    if (r_cnt == '0) begin
                        lwr_data = r_fs;
                    end else if (r_pos == POS_W'(1)) begin
                        lwr_data = r_head;
                    end else begin
                        lwr_data = r_rd_link;
                    end
                    n_state = S_INS_W2;
                end
            end

            // Point the predecessor at the new slot and report.
            S_INS_W2: begin
                if (out_free) begin
                    lwr_en   = 1'b1;
                    lwr_data = r_fs;
                    if (r_cnt == '0) begin
                        lwr_addr = r_fs;
                        n_head   = r_fs;
                        n_tail   = r_fs;
                    end else if (r_pos == POS_W'(1)) begin
                        lwr_addr = r_tail;
                        n_head   = r_fs;
                    end else begin
                        lwr_addr = r_cur;
                        if (r_cur == r_tail) begin
                            n_tail = r_fs;
                        end
                    end
                    n_used[r_fs] = 1'b1;
                    n_cnt        = r_cnt + CW'(1);
                    n_ovalid     = 1'b1;
                    n_ostatus    = ST_OK;
                    n_ovalue     = f_report(r_val);
                    n_opos       = r_pos;
                    n_olast      = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_used    <= '0;
            r_fs_busy <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_used    <= n_used;
            r_fs_busy <= n_fs_busy;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_st      <= n_st;
        r_cur     <= n_cur;
        r_prv     <= n_prv;
        r_idx     <= n_idx;
        r_fs      <= n_fs;
        r_ostatus <= n_ostatus;
        r_ovalue  <= n_ovalue;
        r_opos    <= n_opos;
        r_olast   <= n_olast;
    end

    // Slot pool: one write per memory and one shared read address per cycle.
    always_ff @(posedge i_clk) begin
        if (vwr_en) begin
            mem_value[vwr_addr] <= vwr_data;
        end
        if (lwr_en) begin
            mem_link[lwr_addr] <= lwr_data;
        end
        if (rd_en) begin
            r_rd_value <= mem_value[rd_addr];
            r_rd_link  <= mem_link[rd_addr];
        end
    end

    // Consistency checks on the list bookkeeping.
    `CLPE_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, CMPW'(r_cnt) <= CMPW'(CAPACITY),
        "element count exceeds the pool size")
    `CLPE_ASSERT_ALWAYS(a_used_matches_cnt, i_clk, i_rst_n, $countones(r_used) == int'(r_cnt),
        "used slot flags disagree with the element count")
    `CLPE_ASSERT_IMPLY(a_empty_ends, i_clk, i_rst_n, r_cnt == '0,
        r_head == '0 && r_tail == '0, "empty list does not have head and tail at slot zero")
    `CLPE_ASSERT_IMPLY(a_free_slot, i_clk, i_rst_n, r_state == S_INS_W1 && !r_fs_busy,
        !r_used[r_fs], "insert is about to overwrite a used slot")

endmodule

`default_nettype wire
